### rtl/core/bfk_pkg.sv
// Shared types, constants and a constant function of the Bessel evaluator.
package bfk_pkg;

	localparam int INTERVALS_DEF = 100;
	localparam int FRAC_BITS_DEF = 16;
	localparam int ITEM_RW = 12;
	localparam int QUO_W = 32;
	localparam int CELL_LAT = 25;
	localparam int DIV_CH = 16;
	localparam int DIV_DIGITS = 3;
	localparam int DIV_LAT = 2 * DIV_DIGITS + 2;
	localparam logic [63:0] PIHALF_Q30 = 64'd1686629713;
	localparam logic signed [63:0] INV2PI_Q32 = 64'sd683565276;
	localparam logic [31:0] QUARTER = 32'h4000_0000;

	typedef struct packed {
		logic signed [23:0] x;
		logic [31:0] step_a;
		logic [ITEM_RW-1:0] step_b;
		logic [31:0] q;
		logic [ITEM_RW-1:0] r;
	} bfk_item_t;

	typedef struct packed {
		logic [1:0] quad;
		logic [31:0] a2;
		logic signed [31:0] acc;
		logic [30:0] term;
	} bfk_tay_t;

	function automatic logic signed [63:0] sin_const(input logic [31:0] p);
		logic [63:0] r;
		logic [63:0] a;
		logic [63:0] a2;
		logic [63:0] t;
		logic signed [63:0] s;
		r = {34'd0, p[29:0]};
		if (p[30]) r = 64'h4000_0000 - r;
		a = (r * PIHALF_Q30) >> 30;
		a2 = (a * a) >> 30;
		t = a;
		s = $signed(a);
		t = ((t * a2) >> 30) / 64'd6;
		s = s - $signed(t);
		t = ((t * a2) >> 30) / 64'd20;
		s = s + $signed(t);
		t = ((t * a2) >> 30) / 64'd42;
		s = s - $signed(t);
		t = ((t * a2) >> 30) / 64'd72;
		s = s + $signed(t);
		t = ((t * a2) >> 30) / 64'd110;
		s = s - $signed(t);
		t = ((t * a2) >> 30) / 64'd156;
		s = s + $signed(t);
		return p[31] ? -s : s;
	endfunction

endpackage

### rtl/core/bessel_first_kind_evaluator_core.sv
// Top level of the Bessel J_m(x) evaluator: input register, cell chain, divider.
//
// Use: drive order (signed integer m) and argument (signed Q7.16 x) and
// raise start; an item is taken at every rising edge with start high and
// busy low. busy is always low, so one item can enter every cycle.
// Each item runs through a row of 2*INTERVALS+1 sample cells. Cell k adds
// the weighted cosine sample k of the Simpson sum and hands the running
// sum to the next cell through a register; each cell holds a 24-stage cosine
// pipeline. A three-digit radix 2^16 reciprocal divider then scales the sum.
// The result appears on value, with strobe high for one cycle, after the
// item has passed the input register, the cell chain and the divider.
// Throughput: one item per cycle, set by the fully pipelined cells.
// Results leave in the order of the items. The receiver cannot stall:
// every result is shown once, on its strobe cycle.
// Reset clears only the strobe pipeline; items in flight are dropped.
module bessel_first_kind_evaluator_core import bfk_pkg::*; #(
	parameter int INTERVALS = INTERVALS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic signed [5:0]           order,
	input  logic signed [23:0]          argument,
	output logic                        strobe,
	output logic signed [FRAC_BITS+1:0] value
);

	localparam int D = 4 * INTERVALS;
	localparam int NCELL = 2 * INTERVALS + 1;
	localparam int SW = 34 + $clog2(6 * INTERVALS);
	localparam int DEPTH = 2 * INTERVALS + CELL_LAT + 1;
	localparam logic signed [FRAC_BITS+1:0] LIM = (FRAC_BITS + 2)'(1) << FRAC_BITS;

	logic [31:0] tab_a [64];
	logic [ITEM_RW-1:0] tab_b [64];
	bfk_item_t item_s0;
	bfk_item_t item [NCELL+1];
	logic signed [SW-1:0] sums [NCELL+1];
	logic [DEPTH-1:0] chain_v_q;

	for (genvar i = 0; i < 64; i++) begin : g_tab
		localparam int MI = (i < 32) ? i : i - 64 + D;
		localparam logic [63:0] NUM = 64'(MI) << 32;
		localparam logic [63:0] AI = NUM / 64'(D);
		localparam logic [63:0] BI = NUM % 64'(D);
		assign tab_a[i] = AI[31:0];
		assign tab_b[i] = BI[ITEM_RW-1:0];
	end

	assign busy = 1'b0;

	always_ff @(posedge clk) begin
		item_s0.x <= argument;
		item_s0.step_a <= tab_a[$unsigned(order)];
		item_s0.step_b <= tab_b[$unsigned(order)];
		item_s0.q <= '0;
		item_s0.r <= ITEM_RW'(D / 2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_v_q <= '0;
		end else begin
			chain_v_q <= {chain_v_q[DEPTH-2:0], start & ~busy};
		end
	end

	assign item[0] = item_s0;
	assign sums[0] = '0;

	for (genvar k = 0; k < NCELL; k++) begin : g_cell
		bfk_cell #(.INTERVALS(INTERVALS), .K(k), .SW(SW)) u_cell (
			.clk     (clk),
			.item_in (item[k]),
			.item_out(item[k+1]),
			.sum_in  (sums[k]),
			.sum_out (sums[k+1])
		);
	end

	bfk_div #(.INTERVALS(INTERVALS), .FRAC_BITS(FRAC_BITS), .SW(SW)) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid_in(chain_v_q[DEPTH-1]),
		.sum     (sums[NCELL]),
		.strobe  (strobe),
		.value   (value)
	);

	a_start_to_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##(DEPTH + DIV_LAT) strobe)
		else $error("item accepted without a result at the expected cycle");

	a_strobe_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(start, DEPTH + DIV_LAT))
		else $error("result strobe without a matching item");

	a_value_range: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (value <= LIM && value >= -LIM))
		else $error("result outside saturation range");

endmodule

### rtl/core/bfk_term.sv
// One pipelined Taylor term of the sine series: multiply, divide by a constant, accumulate.
module bfk_term import bfk_pkg::*; #(
	parameter int TERM = 1
) (
	input  logic     clk,
	input  bfk_tay_t tin,
	output bfk_tay_t tout
);

	localparam int DIV = (2 * TERM) * (2 * TERM + 1);
	localparam logic [63:0] RECIP = (64'(1) << 32) / 64'(DIV);

	logic [62:0] p_s1;
	bfk_tay_t h_s1, h_s2;
	logic [31:0] v_s2, qe_s2;
	logic [63:0] qm;
	logic [39:0] rem;
	logic [31:0] qc;

	always_comb begin
		qm = 64'(p_s1[61:30]) * RECIP;
		rem = 40'(v_s2) - 40'(qe_s2) * 40'(DIV);
		qc = (rem >= 40'(DIV)) ? qe_s2 + 32'd1 : qe_s2;
	end

	always_ff @(posedge clk) begin
		p_s1 <= 63'(tin.term) * 63'(tin.a2);
		h_s1 <= tin;
		v_s2 <= p_s1[61:30];
		qe_s2 <= qm[63:32];
		h_s2 <= h_s1;
		tout.quad <= h_s2.quad;
		tout.a2 <= h_s2.a2;
		tout.term <= qc[30:0];
		if (TERM % 2 == 1) begin
			tout.acc <= h_s2.acc - $signed(qc);
		end else begin
			tout.acc <= h_s2.acc + $signed(qc);
		end
	end

endmodule

### rtl/core/bfk_cell.sv
// One sample cell: phase step to the neighbor, cosine pipeline, weighted sum hand-off.
module bfk_cell import bfk_pkg::*; #(
	parameter int INTERVALS = INTERVALS_DEF,
	parameter int K = 0,
	parameter int SW = 44
) (
	input  logic                 clk,
	input  bfk_item_t            item_in,
	output bfk_item_t            item_out,
	input  logic signed [SW-1:0] sum_in,
	output logic signed [SW-1:0] sum_out
);

	localparam int D = 4 * INTERVALS;
	localparam logic [63:0] PHK = ((64'(K) << 32) + 64'(D / 2)) / 64'(D);
	localparam logic signed [63:0] STK = sin_const(PHK[31:0]);
	localparam logic signed [31:0] ST = STK[31:0];
	localparam int WSH = (K == 0 || K == 2 * INTERVALS) ? 0 : ((K % 2 == 1) ? 2 : 1);

	logic [ITEM_RW:0] r_sum;
	logic wrap;

	logic signed [55:0] prod_s1;
	logic [31:0] pm_s1, pm_s2, pm_s3;
	logic signed [33:0] rad_s2;
	logic signed [63:0] tp_s3;
	logic [1:0] quad_s4, quad_s5;
	logic [30:0] r_s4;
	logic [30:0] a_s5;
	bfk_tay_t tay_s6;
	bfk_tay_t tay [0:6];

	logic [55:0] mag1, rad_m;
	logic [63:0] mag3, rnd3;
	logic [31:0] low3, turns3, cp3;
	logic [61:0] pr5, pa6;
	logic signed [31:0] c;

	always_comb begin
		r_sum = {1'b0, item_in.r} + {1'b0, item_in.step_b};
		wrap = r_sum >= (ITEM_RW + 1)'(D);
		mag1 = prod_s1[55] ? 56'(-prod_s1) : 56'(prod_s1);
		rad_m = (mag1 + (56'(1) << 21)) >> 22;
		mag3 = tp_s3[63] ? 64'(-tp_s3) : 64'(tp_s3);
		rnd3 = (mag3 + (64'(1) << 23)) >> 24;
		low3 = rnd3[31:0];
		turns3 = tp_s3[63] ? -low3 : low3;
		cp3 = pm_s3 - turns3 + QUARTER;
		pr5 = 62'(r_s4) * 62'(PIHALF_Q30);
		pa6 = 62'(a_s5) * 62'(a_s5);
		c = tay[6].quad[1] ? -tay[6].acc : tay[6].acc;
	end

	always_ff @(posedge clk) begin
		item_out.x <= item_in.x;
		item_out.step_a <= item_in.step_a;
		item_out.step_b <= item_in.step_b;
		item_out.q <= item_in.q + item_in.step_a + 32'(wrap);
		item_out.r <= wrap ? ITEM_RW'(r_sum - (ITEM_RW + 1)'(D)) : r_sum[ITEM_RW-1:0];

		prod_s1 <= 56'(item_in.x) * 56'(ST);
		pm_s1 <= item_in.q;
		rad_s2 <= prod_s1[55] ? -34'(rad_m) : 34'(rad_m);
		pm_s2 <= pm_s1;
		tp_s3 <= 64'(rad_s2) * INV2PI_Q32;
		pm_s3 <= pm_s2;
		quad_s4 <= cp3[31:30];
		r_s4 <= cp3[30] ? 31'(QUARTER) - 31'(cp3[29:0]) : 31'(cp3[29:0]);
		a_s5 <= pr5[60:30];
		quad_s5 <= quad_s4;
		tay_s6.quad <= quad_s5;
		tay_s6.a2 <= pa6[61:30];
		tay_s6.acc <= $signed(32'(a_s5));
		tay_s6.term <= a_s5;
		sum_out <= sum_in + (SW'(c) <<< WSH);
	end

	assign tay[0] = tay_s6;

	for (genvar n = 1; n <= 6; n++) begin : g_term
		bfk_term #(.TERM(n)) u_term (
			.clk (clk),
			.tin (tay[n-1]),
			.tout(tay[n])
		);
	end

endmodule

### rtl/core/bfk_div.sv
// Pipelined rounding divide by 6*INTERVALS, final rounding shift and saturation.
module bfk_div import bfk_pkg::*; #(
	parameter int INTERVALS = INTERVALS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int SW = 44
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        valid_in,
	input  logic signed [SW-1:0]        sum,
	output logic                        strobe,
	output logic signed [FRAC_BITS+1:0] value
);

	localparam int D6 = 6 * INTERVALS;
	localparam int SH = 30 - FRAC_BITS;
	localparam int RW = $clog2(D6);
	localparam int VW = RW + DIV_CH;
	localparam int NW = DIV_DIGITS * DIV_CH;
	localparam logic [63:0] HALF = (64'(1) << SH) >> 1;
	localparam logic [32:0] LIM = 33'(1) << FRAC_BITS;
	localparam logic [31:0] RECIP = 32'((64'(1) << 32) / 64'(D6));

	logic [NW-1:0] num_q [DIV_DIGITS+1];
	logic [RW-1:0] rem_q [DIV_DIGITS+1];
	logic [QUO_W-1:0] quo_q [DIV_DIGITS+1];
	logic neg_q [DIV_DIGITS+1];
	logic [2*DIV_DIGITS:0] v_q;
	logic [32:0] rm, sat;

	always_comb begin
		rm = (33'(quo_q[DIV_DIGITS]) + 33'(HALF)) >> SH;
		sat = (rm > LIM) ? LIM : rm;
	end

	always_ff @(posedge clk) begin
		num_q[0] <= NW'($unsigned((sum < 0) ? -sum : sum)) + NW'(D6 / 2);
		rem_q[0] <= '0;
		quo_q[0] <= '0;
		neg_q[0] <= sum < 0;
		value <= neg_q[DIV_DIGITS] ? -(FRAC_BITS + 2)'(sat) : (FRAC_BITS + 2)'(sat);
	end

	for (genvar i = 0; i < DIV_DIGITS; i++) begin : g_digit
		localparam int TOP = NW - 1 - i * DIV_CH;
		logic [VW-1:0] v;
		logic [63:0] prod;
		logic [VW-1:0] v_s1;
		logic [DIV_CH-1:0] qe_s1;
		logic [NW-1:0] num_s1;
		logic [QUO_W-1:0] quo_s1;
		logic neg_s1;
		logic [VW-1:0] rem_t;
		logic hit;

		always_comb begin
			v = {rem_q[i], num_q[i][TOP-:DIV_CH]};
			prod = 64'(v) * 64'(RECIP);
			rem_t = v_s1 - VW'(qe_s1) * VW'(D6);
			hit = rem_t >= VW'(D6);
		end

		always_ff @(posedge clk) begin
			v_s1 <= v;
			qe_s1 <= prod[32+:DIV_CH];
			num_s1 <= num_q[i];
			quo_s1 <= quo_q[i];
			neg_s1 <= neg_q[i];
			rem_q[i+1] <= hit ? RW'(rem_t - VW'(D6)) : RW'(rem_t);
			quo_q[i+1] <= {quo_s1[QUO_W-DIV_CH-1:0], qe_s1 + DIV_CH'(hit)};
			num_q[i+1] <= num_s1;
			neg_q[i+1] <= neg_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
			strobe <= 1'b0;
		end else begin
			v_q <= {v_q[2*DIV_DIGITS-1:0], valid_in};
			strobe <= v_q[2*DIV_DIGITS];
		end
	end

endmodule
